[src/swrm_pkg.sv]
`timescale 1ns / 1ps

package swrm_pkg;

  localparam int unsigned DATA_W            = 32;
  localparam int unsigned SCALE_W           = 16;
  localparam int unsigned PROD_W            = DATA_W + SCALE_W;
  localparam int unsigned SWRM_WINDOW_DEPTH = 5;
  localparam int unsigned CFG_ADDR_W        = 3;
  localparam int unsigned CFG_DATA_W        = 32;

  localparam logic [SCALE_W-1:0] RATE_SCALE_RESET = SCALE_W'(1000);

  // Register index, taken from the word address bit paddr[2].
  localparam logic REG_RATE_SCALE = 1'b0;

endpackage

[src/swrm_if.sv]
`timescale 1ns / 1ps

interface swrm_in_if;
  import swrm_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] count_added;
  logic [DATA_W-1:0] timestamp_ms;

  modport source (output valid, output count_added, output timestamp_ms, input ready);
  modport sink   (input valid, input count_added, input timestamp_ms, output ready);
endinterface

interface swrm_out_if;
  import swrm_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] running_total;
  logic [DATA_W-1:0] accumulated_total;
  logic [DATA_W-1:0] rate_value;
  logic              rate_updated;

  modport source (output valid, output running_total, output accumulated_total,
                  output rate_value, output rate_updated, input ready);
  modport sink   (input valid, input running_total, input accumulated_total,
                  input rate_value, input rate_updated, output ready);
endinterface

[src/swrm_cfg.sv]
`timescale 1ns / 1ps

module swrm_cfg
  import swrm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [SCALE_W-1:0]    rate_scale_o
);

  logic [SCALE_W-1:0] rate_scale_q;
  logic               sel_scale;

  assign sel_scale    = (paddr[2] == REG_RATE_SCALE);
  assign pready       = 1'b1;
  assign rate_scale_o = rate_scale_q;
  assign prdata       = sel_scale ? CFG_DATA_W'(rate_scale_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_scale_q <= RATE_SCALE_RESET;
    end else if (psel && penable && pwrite && sel_scale) begin
      rate_scale_q <= pwdata[SCALE_W-1:0];
    end
  end

endmodule

[src/swrm_window.sv]
`timescale 1ns / 1ps

module swrm_window
  import swrm_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = SWRM_WINDOW_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] count_i,
  input  logic [DATA_W-1:0] time_i,
  output logic [DATA_W-1:0] running_o,
  output logic [DATA_W-1:0] acc_o,
  output logic [DATA_W-1:0] dt_o,
  output logic [DATA_W-1:0] dp_o
);

  logic [DATA_W-1:0] time_q  [WINDOW_DEPTH];
  logic [DATA_W-1:0] total_q [WINDOW_DEPTH];
  logic [DATA_W-1:0] running_q;
  logic [DATA_W-1:0] acc_q;
  logic [DATA_W-1:0] acc_d;
  logic [DATA_W-1:0] dt_q;
  logic [DATA_W-1:0] dp_q;

  assign acc_d     = acc_q + count_i;
  assign running_o = running_q;
  assign acc_o     = acc_q;
  assign dt_o      = dt_q;
  assign dp_o      = dp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        time_q[i]  <= '0;
        total_q[i] <= '0;
      end
      running_q <= '0;
      acc_q     <= '0;
      dt_q      <= '0;
      dp_q      <= '0;
    end else if (push_i) begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
        time_q[i]  <= time_q[i+1];
        total_q[i] <= total_q[i+1];
      end
      time_q[WINDOW_DEPTH-1]  <= time_i;
      total_q[WINDOW_DEPTH-1] <= acc_d;
      running_q <= running_q + count_i;
      acc_q     <= acc_d;
      // The entry at position one becomes the oldest survivor after the shift.
      dt_q      <= time_i - time_q[1];
      dp_q      <= acc_d - total_q[1];
    end
  end

endmodule

[src/swrm_div.sv]
`timescale 1ns / 1ps

module swrm_div
  import swrm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SCALE_W-1:0] scale_i,
  input  logic [DATA_W-1:0]  dp_i,
  input  logic [DATA_W-1:0]  dt_i,
  output logic               done_o,
  output logic [DATA_W-1:0]  quot_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  typedef enum logic [1:0] {DV_IDLE, DV_MUL, DV_RUN} div_state_e;

  div_state_e         state_q;
  logic [SCALE_W-1:0] scale_q;
  logic [DATA_W-1:0]  dp_q;
  logic [DATA_W-1:0]  dt_q;
  logic [DATA_W-1:0]  rem_q;
  logic [DATA_W-1:0]  quo_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               done_q;

  logic [PROD_W-1:0]  prod;
  logic               sat;
  logic [DATA_W:0]    rem_sh;
  logic [DATA_W:0]    rem_diff;
  logic               ge;

  assign prod     = PROD_W'(scale_q) * PROD_W'(dp_q);
  // The quotient overflows 32 bits exactly when the upper product bits reach the divisor.
  assign sat      = DATA_W'(prod[PROD_W-1:DATA_W]) >= dt_q;
  assign rem_sh   = {rem_q, quo_q[DATA_W-1]};
  assign rem_diff = rem_sh - {1'b0, dt_q};
  assign ge       = !rem_diff[DATA_W];

  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        DV_IDLE: begin
          if (start_i) begin
            scale_q <= scale_i;
            dp_q    <= dp_i;
            dt_q    <= dt_i;
            state_q <= DV_MUL;
          end
        end
        DV_MUL: begin
          if (sat) begin
            quo_q   <= '1;
            done_q  <= 1'b1;
            state_q <= DV_IDLE;
          end else begin
            rem_q   <= DATA_W'(prod[PROD_W-1:DATA_W]);
            quo_q   <= prod[DATA_W-1:0];
            cnt_q   <= '0;
            state_q <= DV_RUN;
          end
        end
        DV_RUN: begin
          rem_q <= ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
          quo_q <= {quo_q[DATA_W-2:0], ge};
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(DATA_W - 1)) begin
            done_q  <= 1'b1;
            state_q <= DV_IDLE;
          end
        end
        default: state_q <= DV_IDLE;
      endcase
    end
  end

endmodule

[src/sliding_window_event_rate_meter_top.sv]
`timescale 1ns / 1ps

// Sliding-window event rate meter. Each event transfer adds its count to the running and
// accumulated totals and is compared with the event WINDOW_DEPTH-1 transfers earlier; one
// result transfer follows per event. Events are handled one at a time, in order: the window
// update, the 16 by 32 bit scale multiply and the bit-serial restoring divider, which is
// skipped when the quotient saturates; an event whose time difference is zero skips the
// multiply and divider and repeats the last rate. A finished result sits in an output
// register, so the next event is taken while it waits.
module sliding_window_event_rate_meter_top
  import swrm_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = SWRM_WINDOW_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  swrm_in_if.sink               in_i,
  swrm_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_DIV, ST_RESULT} state_e;

  state_e             state_q;
  logic [DATA_W-1:0]  last_rate_q;
  logic [DATA_W-1:0]  res_rate_q;
  logic               res_upd_q;
  logic               out_valid_q;
  logic [DATA_W-1:0]  out_running_q;
  logic [DATA_W-1:0]  out_acc_q;
  logic [DATA_W-1:0]  out_rate_q;
  logic               out_upd_q;

  logic [SCALE_W-1:0] rate_scale;
  logic [DATA_W-1:0]  running;
  logic [DATA_W-1:0]  acc;
  logic [DATA_W-1:0]  dt;
  logic [DATA_W-1:0]  dp;
  logic               push;
  logic               div_start;
  logic               div_done;
  logic [DATA_W-1:0]  quot;
  logic               out_free;

  assign in_i.ready = (state_q == ST_IDLE);
  assign push       = in_i.valid && in_i.ready;
  assign div_start  = (state_q == ST_CALC) && (dt != '0);
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid             = out_valid_q;
  assign out_o.running_total     = out_running_q;
  assign out_o.accumulated_total = out_acc_q;
  assign out_o.rate_value        = out_rate_q;
  assign out_o.rate_updated      = out_upd_q;

  swrm_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .rate_scale_o (rate_scale)
  );

  swrm_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .count_i   (in_i.count_added),
    .time_i    (in_i.timestamp_ms),
    .running_o (running),
    .acc_o     (acc),
    .dt_o      (dt),
    .dp_o      (dp)
  );

  swrm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .scale_i (rate_scale),
    .dp_i    (dp),
    .dt_i    (dt),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_rate_q <= '0;
      out_valid_q <= 1'b0;
      res_upd_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != ST_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (push) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (dt == '0) begin
            res_rate_q <= last_rate_q;
            res_upd_q  <= 1'b0;
            state_q    <= ST_RESULT;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            last_rate_q <= quot;
            res_rate_q  <= quot;
            res_upd_q   <= 1'b1;
            state_q     <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_running_q <= running;
            out_acc_q     <= acc;
            out_rate_q    <= res_rate_q;
            out_upd_q     <= res_upd_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
